// ===== hdl/fdrs_pkg.sv =====
package fdrs_pkg;

    localparam int FIELD_BITS = 16;

    // opcode values on the input word
    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_SELECT   = 2'd1;
    localparam logic [1:0] OP_COMPLETE = 2'd2;

    // status codes on the result word
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_NO_ONGOING = 2'd2;

    // served queue encoding
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_A    = 2'd1;
    localparam logic [1:0] ACT_B    = 2'd2;

    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_SELECT,
        KIND_COMPLETE,
        KIND_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [FIELD_BITS-1:0] track;
        logic [FIELD_BITS-1:0] id;
        logic [FIELD_BITS-1:0] head;
    } cmd_t;

    typedef struct packed {
        logic                  selected_valid;
        logic [FIELD_BITS-1:0] selected_id;
        logic [FIELD_BITS-1:0] selected_track;
        logic                  pending;
        logic [1:0]            status;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DECIDE,
        S_MOVE,
        S_FRONT,
        S_RESULT
    } eng_state_t;

endpackage

// ===== hdl/fdrs_front.sv =====
module fdrs_front
    import fdrs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_pop
);

    cmd_t       ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    cmd_t       cmd_in;

    function automatic cmd_kind_t decode(input logic [1:0] op);
        cmd_kind_t k;
        case (op)
            OP_ADD:      k = KIND_ADD;
            OP_SELECT:   k = KIND_SELECT;
            OP_COMPLETE: k = KIND_COMPLETE;
            default:     k = KIND_NOP;
        endcase
        return k;
    endfunction

    always_comb begin
        cmd_in.kind  = decode(s_tuser);
        cmd_in.track = s_tdata[15:0];
        cmd_in.id    = s_tdata[31:16];
        cmd_in.head  = s_tdata[47:32];
    end

    assign s_tready  = (fill_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = ent_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== hdl/fdrs_back.sv =====
module fdrs_back
    import fdrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int TRACK_BITS  = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    localparam int IW    = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int AW    = IW + 1;
    localparam int MEM_N = 2 ** AW;
    localparam int TW    = (TRACK_BITS < FIELD_BITS) ? TRACK_BITS : FIELD_BITS;
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    logic [TW-1:0]         mem_trk [MEM_N];
    logic [FIELD_BITS-1:0] mem_id  [MEM_N];
    logic [TW-1:0]         rd_trk_reg;
    logic [FIELD_BITS-1:0] rd_id_reg;

    logic                  rd_en, wr_en;
    logic [AW-1:0]         rd_addr, wr_addr;
    logic [TW-1:0]         wr_trk;
    logic [FIELD_BITS-1:0] wr_id;

    eng_state_t state_reg, state_next;

    logic [CW-1:0] cnt0_reg, cnt0_next, cnt1_reg, cnt1_next;
    logic [1:0]    active_reg, active_next;
    logic          scan_up_reg, scan_up_next;
    cmd_t          cmd_reg, cmd_next;
    logic          q_reg, q_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;

    logic                  up_found_reg, up_found_next, dn_found_reg, dn_found_next;
    logic [IW-1:0]         up_idx_reg, up_idx_next, dn_idx_reg, dn_idx_next;
    logic [TW-1:0]         up_dist_reg, up_dist_next, dn_dist_reg, dn_dist_next;
    logic [TW-1:0]         up_trk_reg, up_trk_next, dn_trk_reg, dn_trk_next;
    logic [FIELD_BITS-1:0] up_id_reg, up_id_next, dn_id_reg, dn_id_next;

    logic                  sel_valid_reg, sel_valid_next;
    logic [TW-1:0]         sel_trk_reg, sel_trk_next;
    logic [FIELD_BITS-1:0] sel_id_reg, sel_id_next;
    logic [1:0]            status_reg, status_next;

    logic [IW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] left_reg, left_next;
    logic          mv_up_reg, mv_up_next;
    logic          wr_pend_reg, wr_pend_next;
    logic [IW-1:0] wa_reg, wa_next;

    logic  out_valid_reg, out_valid_next;
    res_t  out_res_reg, out_res_next;

    logic          q_act;
    logic [CW-1:0] n_act;
    logic          sel_go, cmp_go, use_up;
    logic [TW-1:0] head_m;

    assign q_act  = (active_reg == ACT_B);
    assign n_act  = q_act ? cnt1_reg : cnt0_reg;
    assign sel_go = (active_reg != ACT_NONE) && (n_act != '0);
    assign cmp_go = sel_go;
    assign head_m = cmd_reg.head[TW-1:0];

    // n == 1 takes the lone entry without touching the sweep direction
    always_comb begin
        if (n_reg == CW'(1)) begin
            use_up = up_found_reg;
        end else if (scan_up_reg) begin
            use_up = up_found_reg;
        end else begin
            use_up = !dn_found_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd_valid && !out_valid_reg) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (cmd_reg.kind == KIND_SELECT && sel_go) begin
                    state_next = S_SCAN;
                end else if (cmd_reg.kind == KIND_COMPLETE && cmp_go) begin
                    state_next = S_MOVE;
                end else begin
                    state_next = S_RESULT;
                end
            end
            S_SCAN: begin
                if (issue_reg == n_reg && !rd_vld_reg) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: state_next = S_MOVE;
            S_MOVE: begin
                if (left_reg == '0 && !wr_pend_reg) begin
                    state_next = (cmd_reg.kind == KIND_SELECT) ? S_FRONT : S_RESULT;
                end
            end
            S_FRONT:  state_next = S_RESULT;
            S_RESULT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cnt0_next      = cnt0_reg;
        cnt1_next      = cnt1_reg;
        active_next    = active_reg;
        scan_up_next   = scan_up_reg;
        cmd_next       = cmd_reg;
        q_next         = q_reg;
        n_next         = n_reg;
        issue_next     = issue_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        up_found_next  = up_found_reg;
        up_idx_next    = up_idx_reg;
        up_dist_next   = up_dist_reg;
        up_trk_next    = up_trk_reg;
        up_id_next     = up_id_reg;
        dn_found_next  = dn_found_reg;
        dn_idx_next    = dn_idx_reg;
        dn_dist_next   = dn_dist_reg;
        dn_trk_next    = dn_trk_reg;
        dn_id_next     = dn_id_reg;
        sel_valid_next = sel_valid_reg;
        sel_trk_next   = sel_trk_reg;
        sel_id_next    = sel_id_reg;
        status_next    = status_reg;
        ptr_next       = ptr_reg;
        left_next      = left_reg;
        mv_up_next     = mv_up_reg;
        wr_pend_next   = wr_pend_reg;
        wa_next        = wa_reg;
        out_res_next   = out_res_reg;
        out_valid_next = (out_valid_reg && out_ready) ? 1'b0 : out_valid_reg;
        cmd_pop        = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_trk         = '0;
        wr_id          = '0;

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid && !out_valid_reg) begin
                    cmd_pop        = 1'b1;
                    cmd_next       = cmd;
                    status_next    = ST_OK;
                    sel_valid_next = 1'b0;
                    sel_trk_next   = '0;
                    sel_id_next    = '0;
                end
            end
            S_EXEC: begin
                case (cmd_reg.kind)
                    KIND_ADD: begin
                        // adds go to the queue not in service; A when idle
                        if ((active_reg == ACT_A ? cnt1_reg : cnt0_reg) >= DEPTH_C) begin
                            status_next = ST_FULL;
                        end else begin
                            wr_en  = 1'b1;
                            wr_trk = cmd_reg.track[TW-1:0];
                            wr_id  = cmd_reg.id;
                            if (active_reg == ACT_A) begin
                                wr_addr   = {1'b1, cnt1_reg[IW-1:0]};
                                cnt1_next = cnt1_reg + CW'(1);
                            end else begin
                                wr_addr   = {1'b0, cnt0_reg[IW-1:0]};
                                cnt0_next = cnt0_reg + CW'(1);
                            end
                            if (active_reg == ACT_NONE) begin
                                active_next = ACT_A;
                            end
                        end
                    end
                    KIND_SELECT: begin
                        q_next        = q_act;
                        n_next        = n_act;
                        issue_next    = '0;
                        up_found_next = 1'b0;
                        dn_found_next = 1'b0;
                    end
                    KIND_COMPLETE: begin
                        if (cmp_go) begin
                            q_next       = q_act;
                            left_next    = n_act - CW'(1);
                            ptr_next     = IW'(1);
                            mv_up_next   = 1'b1;
                            wr_pend_next = 1'b0;
                            if (q_act) begin
                                cnt1_next = cnt1_reg - CW'(1);
                            end else begin
                                cnt0_next = cnt0_reg - CW'(1);
                            end
                            if (n_act == CW'(1)) begin
                                scan_up_next = 1'b1;
                                if ((q_act ? cnt0_reg : cnt1_reg) != '0) begin
                                    active_next = q_act ? ACT_A : ACT_B;
                                end else begin
                                    active_next = ACT_NONE;
                                end
                            end
                        end else begin
                            status_next = ST_NO_ONGOING;
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                if (issue_reg < n_reg) begin
                    rd_en       = 1'b1;
                    rd_addr     = {q_reg, issue_reg[IW-1:0]};
                    issue_next  = issue_reg + CW'(1);
                    rd_idx_next = issue_reg[IW-1:0];
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg) begin
                    // strict less keeps the entry nearest the front on ties
                    if (rd_trk_reg >= head_m) begin
                        if (!up_found_reg || (rd_trk_reg - head_m) < up_dist_reg) begin
                            up_found_next = 1'b1;
                            up_idx_next   = rd_idx_reg;
                            up_dist_next  = rd_trk_reg - head_m;
                            up_trk_next   = rd_trk_reg;
                            up_id_next    = rd_id_reg;
                        end
                    end
                    if (rd_trk_reg <= head_m) begin
                        if (!dn_found_reg || (head_m - rd_trk_reg) < dn_dist_reg) begin
                            dn_found_next = 1'b1;
                            dn_idx_next   = rd_idx_reg;
                            dn_dist_next  = head_m - rd_trk_reg;
                            dn_trk_next   = rd_trk_reg;
                            dn_id_next    = rd_id_reg;
                        end
                    end
                end
            end
            S_DECIDE: begin
                if (n_reg != CW'(1) && use_up != scan_up_reg) begin
                    scan_up_next = use_up;
                end
                sel_valid_next = 1'b1;
                sel_trk_next   = use_up ? up_trk_reg : dn_trk_reg;
                sel_id_next    = use_up ? up_id_reg : dn_id_reg;
                left_next      = CW'(use_up ? up_idx_reg : dn_idx_reg);
                ptr_next       = (use_up ? up_idx_reg : dn_idx_reg) - IW'(1);
                mv_up_next     = 1'b0;
                wr_pend_next   = 1'b0;
            end
            S_MOVE: begin
                // read one slot, write it one place over on the next cycle
                if (wr_pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = {q_reg, wa_reg};
                    wr_trk  = rd_trk_reg;
                    wr_id   = rd_id_reg;
                end
                if (left_reg != '0) begin
                    rd_en        = 1'b1;
                    rd_addr      = {q_reg, ptr_reg};
                    wr_pend_next = 1'b1;
                    wa_next      = mv_up_reg ? ptr_reg - IW'(1) : ptr_reg + IW'(1);
                    ptr_next     = mv_up_reg ? ptr_reg + IW'(1) : ptr_reg - IW'(1);
                    left_next    = left_reg - CW'(1);
                end else begin
                    wr_pend_next = 1'b0;
                end
            end
            S_FRONT: begin
                wr_en   = 1'b1;
                wr_addr = {q_reg, IW'(0)};
                wr_trk  = sel_trk_reg;
                wr_id   = sel_id_reg;
            end
            S_RESULT: begin
                out_valid_next              = 1'b1;
                out_res_next.selected_valid = sel_valid_reg;
                out_res_next.selected_id    = sel_id_reg;
                out_res_next.selected_track = FIELD_BITS'(sel_trk_reg);
                out_res_next.pending        = (cnt0_reg != '0) || (cnt1_reg != '0);
                out_res_next.status         = status_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_trk[wr_addr] <= wr_trk;
            mem_id[wr_addr]  <= wr_id;
        end
        if (rd_en) begin
            rd_trk_reg <= mem_trk[rd_addr];
            rd_id_reg  <= mem_id[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        q_reg         <= q_next;
        n_reg         <= n_next;
        issue_reg     <= issue_next;
        rd_idx_reg    <= rd_idx_next;
        up_found_reg  <= up_found_next;
        up_idx_reg    <= up_idx_next;
        up_dist_reg   <= up_dist_next;
        up_trk_reg    <= up_trk_next;
        up_id_reg     <= up_id_next;
        dn_found_reg  <= dn_found_next;
        dn_idx_reg    <= dn_idx_next;
        dn_dist_reg   <= dn_dist_next;
        dn_trk_reg    <= dn_trk_next;
        dn_id_reg     <= dn_id_next;
        sel_valid_reg <= sel_valid_next;
        sel_trk_reg   <= sel_trk_next;
        sel_id_reg    <= sel_id_next;
        status_reg    <= status_next;
        ptr_reg       <= ptr_next;
        left_reg      <= left_next;
        mv_up_reg     <= mv_up_next;
        wa_reg        <= wa_next;
        out_res_reg   <= out_res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt0_reg      <= '0;
            cnt1_reg      <= '0;
            active_reg    <= ACT_NONE;
            scan_up_reg   <= 1'b1;
            rd_vld_reg    <= 1'b0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt0_reg      <= cnt0_next;
            cnt1_reg      <= cnt1_next;
            active_reg    <= active_next;
            scan_up_reg   <= scan_up_next;
            rd_vld_reg    <= rd_vld_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

// ===== hdl/fscan_disk_request_scheduler_core.sv =====
// FSCAN disk request scheduler with two request queues held in one
// single-port-read, single-port-write memory. A front stage decodes input
// words into a two-deep command queue; the back engine runs one command at a
// time and places one result word per input word in an output register.
// In the engine, a complete retires the front entry by copying every
// remaining slot of the served queue down through the memory port. A select
// scans the queue through the one read port (both sweep directions are
// tracked in the same pass), then moves the chosen entry to the front. No
// clearing pass follows reset; the block takes words as soon as reset is
// released.
module fscan_disk_request_scheduler_core
    import fdrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int TRACK_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // request_track, request_id, head_track
    input  logic [1:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // selected_id, selected_track, pending, zero fill
    output logic [2:0]  m_tuser    // selected_valid, status
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    res_t res;

    fdrs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    fdrs_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TRACK_BITS  (TRACK_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {7'd0, res.pending, res.selected_track, res.selected_id};
    assign m_tuser = {res.status, res.selected_valid};

endmodule
